// ----- rtl/vmlt_pkg.sv -----
// Shared types, constants and status codes of the VLAN-aware MAC learning table.
package vmlt_pkg;

    localparam int TABLE_ENTRIES = 64;

    localparam int MAC_W  = 48;
    localparam int KEY_W  = 13;
    localparam int VID_W  = 12;
    localparam int SW_W   = 64;
    localparam int PORT_W = 32;

    localparam logic [1:0] ACT_LEARN   = 2'd0;
    localparam logic [1:0] ACT_FORWARD = 2'd1;
    localparam logic [1:0] ACT_DIRECT  = 2'd2;

    localparam logic [2:0] ST_HIT       = 3'd0;
    localparam logic [2:0] ST_FLOOD     = 3'd1;
    localparam logic [2:0] ST_MISS      = 3'd2;
    localparam logic [2:0] ST_LEARNED   = 3'd3;
    localparam logic [2:0] ST_REFRESHED = 3'd4;
    localparam logic [2:0] ST_MCAST_IGN = 3'd5;
    localparam logic [2:0] ST_FULL      = 3'd6;

    localparam logic [KEY_W-1:0] UNTAGGED_KEY  = 13'h1000;
    localparam logic [MAC_W-1:0] BCAST_MAC     = 48'hFFFF_FFFF_FFFF;
    localparam int               MAC_GROUP_BIT = 40;

    typedef struct packed {
        logic [1:0]        action;
        logic [MAC_W-1:0]  mac_address;
        logic              vlan_tagged;
        logic [VID_W-1:0]  vlan_id;
        logic [SW_W-1:0]   switch_id;
        logic [PORT_W-1:0] port_number;
    } req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [PORT_W-1:0] egress_port;
        logic [SW_W-1:0]   egress_switch_id;
    } rsp_t;

    // Request as it walks along the chain of cells. While pending is set no
    // cell has settled it yet; sw and port carry the learnt values on the way
    // in and the matched entry's values once a lookup has hit.
    typedef struct packed {
        logic              pending;
        logic              learn;
        logic [2:0]        status;
        logic [MAC_W-1:0]  mac;
        logic [KEY_W-1:0]  key;
        logic [SW_W-1:0]   sw;
        logic [PORT_W-1:0] port;
    } token_t;

endpackage

// ----- rtl/vlan_mac_learning_table.sv -----
// Top level of the VLAN-aware MAC learning table: request decode, cell chain, result.
// A result strobes on done once the request has passed the register of every cell of the
// chain and then the result register.
// Throughput: one request per cycle; each cell serves requests strictly in order, so busy
// stays low and results leave in request order, one per cycle at most.
// Reset clears every entry's valid bit and empties the chain at once; no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module vlan_mac_learning_table (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  vmlt_pkg::req_t request,
    output logic          done,
    output vmlt_pkg::rsp_t result
);

    // The table is a row of cells, one entry each. A request enters cell 0 and
    // moves one cell a cycle. A learn settles in the cell that holds its key or
    // in the first empty cell; a lookup settles in the cell that holds its key.
    // Requests that need no table access are settled at the door and simply
    // ride along, which keeps the results in order.

    logic                               tv   [vmlt_pkg::TABLE_ENTRIES+1];
    vmlt_pkg::token_t                   tk   [vmlt_pkg::TABLE_ENTRIES+1];
    vmlt_pkg::token_t                   head_tok;
    logic                               mcast;
    logic                               bcast;
    logic                               done_reg;
    vmlt_pkg::rsp_t                     result_reg;
    vmlt_pkg::rsp_t                     result_next;
    vmlt_pkg::token_t                   last;

    // Every request is accepted: the chain never backs up.
    assign busy = 1'b0;

    assign mcast = request.mac_address[vmlt_pkg::MAC_GROUP_BIT];
    assign bcast = (request.mac_address == vmlt_pkg::BCAST_MAC);

    always_comb
    begin
        head_tok.pending = 1'b0;
        head_tok.learn   = 1'b0;
        head_tok.status  = vmlt_pkg::ST_MISS;
        head_tok.mac     = request.mac_address;
        head_tok.key     = request.vlan_tagged ? {1'b0, request.vlan_id}
                                               : vmlt_pkg::UNTAGGED_KEY;
        head_tok.sw      = request.switch_id;
        head_tok.port    = request.port_number;
        unique case (request.action)
            vmlt_pkg::ACT_LEARN:
            begin
                // A multicast source is never learnt.
                if (mcast)
                begin
                    head_tok.status = vmlt_pkg::ST_MCAST_IGN;
                end
                else
                begin
                    head_tok.pending = 1'b1;
                    head_tok.learn   = 1'b1;
                    head_tok.status  = vmlt_pkg::ST_FULL;
                end
            end
            vmlt_pkg::ACT_FORWARD:
            begin
                // Broadcast is checked before the group bit.
                priority if (bcast)
                begin
                    head_tok.status = vmlt_pkg::ST_FLOOD;
                end
                else if (mcast)
                begin
                    head_tok.status = vmlt_pkg::ST_MISS;
                end
                else
                begin
                    head_tok.pending = 1'b1;
                end
            end
            vmlt_pkg::ACT_DIRECT:
            begin
                head_tok.pending = 1'b1;
            end
            default:
            begin
                head_tok.status = vmlt_pkg::ST_MISS;
            end
        endcase
    end

    assign tk[0] = head_tok;
    assign tv[0] = start;

    for (genvar i = 0; i < vmlt_pkg::TABLE_ENTRIES; i++)
    begin : g_cell
        vmlt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .tok_valid(tv[i]),
            .tok      (tk[i]),
            .out_valid(tv[i+1]),
            .out_tok  (tk[i+1])
        );
    end

    // A request still pending at the end of the chain found no cell: its
    // status was preset to full for a learn and to miss for a lookup. The
    // egress fields are zero for everything but a hit.
    assign last = tk[vmlt_pkg::TABLE_ENTRIES];

    always_comb
    begin
        result_next.status           = last.status;
        result_next.egress_port      = '0;
        result_next.egress_switch_id = '0;
        if (last.status == vmlt_pkg::ST_HIT)
        begin
            result_next.egress_port      = last.port;
            result_next.egress_switch_id = last.sw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= tv[vmlt_pkg::TABLE_ENTRIES];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- rtl/vmlt_cell.sv -----
// One table cell: holds a single entry and serves each passing request.
module vmlt_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            tok_valid,
    input  vmlt_pkg::token_t tok,
    output logic            out_valid,
    output vmlt_pkg::token_t out_tok
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [vmlt_pkg::MAC_W-1:0]  mac_reg;
    logic [vmlt_pkg::KEY_W-1:0]  key_reg;
    logic [vmlt_pkg::SW_W-1:0]   sw_reg;
    logic [vmlt_pkg::PORT_W-1:0] port_reg;
    logic                        tv_reg;
    vmlt_pkg::token_t            tok_reg;
    vmlt_pkg::token_t            tok_next;
    logic                        hit;
    logic                        wr_key;
    logic                        wr_data;

    assign hit = valid_reg && (mac_reg == tok.mac) && (key_reg == tok.key);

    always_comb
    begin
        tok_next   = tok;
        valid_next = valid_reg;
        wr_key     = 1'b0;
        wr_data    = 1'b0;
        if (tok_valid && tok.pending)
        begin
            if (tok.learn)
            begin
                // Entries fill from the head of the chain and are never
                // removed, so the first free cell lies beyond every match.
                if (!valid_reg)
                begin
                    valid_next       = 1'b1;
                    wr_key           = 1'b1;
                    wr_data          = 1'b1;
                    tok_next.pending = 1'b0;
                    tok_next.status  = vmlt_pkg::ST_LEARNED;
                end
                else if (hit)
                begin
                    wr_data          = 1'b1;
                    tok_next.pending = 1'b0;
                    tok_next.status  = vmlt_pkg::ST_REFRESHED;
                end
            end
            else if (hit)
            begin
                tok_next.pending = 1'b0;
                tok_next.status  = vmlt_pkg::ST_HIT;
                tok_next.sw      = sw_reg;
                tok_next.port    = port_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tv_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            tv_reg    <= tok_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (wr_key)
        begin
            mac_reg <= tok.mac;
            key_reg <= tok.key;
        end
        if (wr_data)
        begin
            sw_reg   <= tok.sw;
            port_reg <= tok.port;
        end
    end

    assign out_valid = tv_reg;
    assign out_tok   = tok_reg;

endmodule
